// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the Lua comment and string blanker.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/lcsb_pkg.sv =====
// Shared types and constants for the Lua comment and string blanker.
// No dependencies; imported by every module of the block.
package lcsb_pkg;

  localparam int CHAR_W        = 8;   // width of a character on the streams
  localparam int CHAR_BITS_DEF = 8;   // significant bits of an input character
  localparam int OQ_DEPTH      = 4;   // result queue entries
  localparam int OQ_PTR_W      = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W      = $clog2(OQ_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_DQ    = CHAR_W'(8'h22);
  localparam logic [CHAR_W-1:0] CH_SQ    = CHAR_W'(8'h27);
  localparam logic [CHAR_W-1:0] CH_BSL   = CHAR_W'(8'h5C);
  localparam logic [CHAR_W-1:0] CH_DASH  = CHAR_W'(8'h2D);
  localparam logic [CHAR_W-1:0] CH_LBR   = CHAR_W'(8'h5B);
  localparam logic [CHAR_W-1:0] CH_RBR   = CHAR_W'(8'h5D);
  localparam logic [CHAR_W-1:0] CH_NL    = CHAR_W'(8'h0A);
  localparam logic [CHAR_W-1:0] CH_SPACE = CHAR_W'(8'h20);

  // Results of one scanned character: zero, one or two output characters.
  typedef struct packed {
    logic [1:0]        cnt;
    logic [CHAR_W-1:0] ch0;
    logic [CHAR_W-1:0] ch1;
    logic              last;   // text ends with the last of these results
  } scan_res_t;

endpackage

// ===== rtl/core/lua_comment_string_blanker.sv =====
// Top level of the Lua comment and string blanker: input register, scanner, result queue.
// Depends on lcsb_pkg, lcsb_scan and lcsb_outq.
//
// Use: Lua source enters one character per transaction on the in_ stream;
// in_tlast marks the final character of a text. The out_ stream returns the
// same text with every string literal and comment turned into spaces, while
// newlines always pass through. A lone '-' is held back until the next
// character shows whether it opens a comment, so one input character gives
// zero, one or two output characters; out_tlast marks the final output of a
// text, after which the lexer state returns to normal text.
// Path: a character accepted on in_ is registered in the input register,
// scanned once the result queue has room, written into the queue and then shown on out_tdata.
// Throughput: one character per cycle while out_tready is high, set by the combinational scanner
// and the one-entry-per-cycle read port of the four-entry result queue; a character
// that yields two results holds the output side back for an extra entry.
// Stall: when out_tready is low the queue fills; once fewer than two entries
// are free the scanner stops and in_tready falls after the input register
// fills. Nothing is dropped.
// Reset: rst_n low (synchronous) empties the queue and input register and
// puts the lexer in normal text mode.
module lua_comment_string_blanker
  import lcsb_pkg::*;
#(
  parameter int CHAR_BITS = CHAR_BITS_DEF   // significant bits of an input character
) (
  input  logic              clk,
  input  logic              rst_n,
  // input character stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,    // [7:0] in_char
  input  logic              in_tlast,    // in_last
  // blanked character stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,   // [7:0] out_char
  output logic              out_tlast    // out_last
);

  logic              in_vld_r, in_vld_nxt;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;
  logic              in_take;   // input transaction this cycle
  logic              fire;      // held character goes through the scanner
  logic              q_space;
  scan_res_t         scan_res;

  assign fire       = in_vld_r && q_space;
  assign in_tready  = !in_vld_r || q_space;
  assign in_take    = in_tvalid && in_tready;
  assign in_vld_nxt = in_take || (in_vld_r && !fire);

  // input register: valid under reset, payload loaded on each transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  lcsb_scan #(
    .CHAR_BITS (CHAR_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_char (in_char_r),
    .in_last (in_last_r),
    .res     (scan_res)
  );

  lcsb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (scan_res),
    .space     (q_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== rtl/core/lcsb_scan.sv =====
// Lexer state and per-character blanking decision.
// Depends on lcsb_pkg.
module lcsb_scan
  import lcsb_pkg::*;
#(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  output scan_res_t         res
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_DASH   = 3'd1,
    MODE_DASH2  = 3'd2,
    MODE_DASHBR = 3'd3,
    MODE_LINE   = 3'd4,
    MODE_BLOCK  = 3'd5,
    MODE_STRING = 3'd6
  } mode_t;

  localparam int KEEP_BITS = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;
  localparam logic [CHAR_W-1:0] CHAR_MASK = CHAR_W'((32'd1 << KEEP_BITS) - 32'd1);

  mode_t             mode_r, mode_nxt;
  logic              quote_r, quote_nxt;   // open string used a single quote
  logic              esc_r, esc_nxt;
  logic              rbr_r, rbr_nxt;       // one ']' seen in a block comment
  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] quote_ch;

  // normal-text handling, also used after a held dash
  logic              nrm_put;
  logic [CHAR_W-1:0] nrm_ch;
  mode_t             nrm_mode;
  logic              nrm_quote;
  logic              nrm_esc;

  logic [1:0]        cnt;
  logic [CHAR_W-1:0] ch0, ch1;

  assign c        = in_char & CHAR_MASK;
  assign quote_ch = quote_r ? CH_SQ : CH_DQ;

  always_comb begin
    nrm_put   = 1'b1;
    nrm_ch    = c;
    nrm_mode  = MODE_NORMAL;
    nrm_quote = quote_r;
    nrm_esc   = esc_r;
    if (c == CH_DQ || c == CH_SQ) begin
      nrm_ch    = CH_SPACE;
      nrm_mode  = MODE_STRING;
      nrm_quote = (c == CH_SQ);
      nrm_esc   = 1'b0;
    end else if (c == CH_DASH && !in_last) begin
      nrm_put  = 1'b0;
      nrm_mode = MODE_DASH;
    end
  end

  always_comb begin
    cnt       = 2'd1;
    ch0       = CH_SPACE;
    ch1       = CH_SPACE;
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    rbr_nxt   = rbr_r;
    case (mode_r)
      MODE_DASH: begin
        if (c == CH_DASH) begin
          cnt      = 2'd2;
          mode_nxt = MODE_DASH2;
        end else begin
          ch0       = CH_DASH;
          ch1       = nrm_ch;
          cnt       = nrm_put ? 2'd2 : 2'd1;
          mode_nxt  = nrm_mode;
          quote_nxt = nrm_quote;
          esc_nxt   = nrm_esc;
        end
      end
      MODE_DASH2, MODE_DASHBR: begin
        if (c == CH_NL) begin
          ch0      = CH_NL;
          mode_nxt = MODE_NORMAL;
        end else if (c == CH_LBR) begin
          if (mode_r == MODE_DASH2) begin
            mode_nxt = MODE_DASHBR;
          end else begin
            mode_nxt = MODE_BLOCK;
            rbr_nxt  = 1'b0;
          end
        end else begin
          mode_nxt = MODE_LINE;
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          ch0      = CH_NL;
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (c == CH_NL) begin
          ch0     = CH_NL;
          rbr_nxt = 1'b0;
        end else if (c == CH_RBR) begin
          if (rbr_r) begin
            rbr_nxt  = 1'b0;
            mode_nxt = MODE_NORMAL;
          end else begin
            rbr_nxt = 1'b1;
          end
        end else begin
          rbr_nxt = 1'b0;
        end
      end
      MODE_STRING: begin
        if (esc_r) begin
          ch0     = (c == CH_NL) ? CH_NL : CH_SPACE;
          esc_nxt = 1'b0;
        end else if (c == CH_BSL) begin
          esc_nxt = 1'b1;
        end else if (c == quote_ch) begin
          mode_nxt = MODE_NORMAL;
        end else if (c == CH_NL) begin
          ch0      = CH_NL;
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        // normal text; unused codes fall back to it
        ch0       = nrm_ch;
        cnt       = nrm_put ? 2'd1 : 2'd0;
        mode_nxt  = nrm_mode;
        quote_nxt = nrm_quote;
        esc_nxt   = nrm_esc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && in_last)) begin
      mode_r  <= MODE_NORMAL;
      quote_r <= 1'b0;
      esc_r   <= 1'b0;
      rbr_r   <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      rbr_r   <= rbr_nxt;
    end
  end

  always_comb begin
    res.cnt  = fire ? cnt : 2'd0;
    res.ch0  = ch0;
    res.ch1  = ch1;
    res.last = in_last;
  end

endmodule

// ===== rtl/core/lcsb_outq.sv =====
// Small result queue: takes up to two characters a cycle, gives one.
// Depends on lcsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcsb_outq
  import lcsb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  scan_res_t         push,
  output logic              space,       // room for two more entries
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } oq_entry_t;

  oq_entry_t             mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]   count_r, count_nxt;
  logic                  pop;
  logic [OQ_PTR_W-1:0]   wr_ptr_p1;

  assign pop        = out_valid && out_ready;
  assign wr_ptr_p1  = wr_ptr_r + OQ_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + OQ_PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + OQ_PTR_W'(pop);
  assign count_nxt  = count_r + OQ_CNT_W'(push.cnt) - OQ_CNT_W'(pop);

  assign space     = (count_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_char  = mem[rd_ptr_r].ch;
  assign out_last  = mem[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= '{ch: push.ch0, last: push.last && (push.cnt == 2'd1)};
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= '{ch: push.ch1, last: push.last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst_n, count_r <= OQ_CNT_W'(OQ_DEPTH), "result queue overfilled")
  `ASSERT_CLK(a_push_room, clk, rst_n, (push.cnt != 2'd0) |-> space, "push without room")
  `ASSERT_CLK(a_no_three, clk, rst_n, push.cnt != 2'd3, "three results from one character")
  `ASSERT_CLK(a_ptr_gap, clk, rst_n, OQ_PTR_W'(wr_ptr_r - rd_ptr_r) == OQ_PTR_W'(count_r), "queue pointers and count disagree")

endmodule

// ===== tb/sv/lcsb_checker.sv =====
// Checker for the Lua comment and string blanker: watches both streams, predicts, compares.
// Depends on lcsb_pkg for character codes and widths.
module lcsb_checker
  import lcsb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,    // [7:0] in_char
  input  logic              in_tlast,    // in_last
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [CHAR_W-1:0] out_tdata,   // [7:0] out_char
  input  logic              out_tlast,   // out_last
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    LX_TEXT, LX_DASH, LX_DASH2, LX_DASH_BR, LX_LINE, LX_BLOCK, LX_STRING
  } lex_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } out_char_t;

  localparam logic [CHAR_W-1:0] CHAR_MASK = CHAR_W'((1 << CHAR_BITS_DEF) - 1);

  lex_mode_t   mode;
  logic        single_q;
  logic        esc_open;
  logic        rbr_seen;
  int          n_step;
  out_char_t   blanked_text[$];   // output characters still to come, oldest first

  initial fail_count = 0;

  function void reset_lexer();
    mode     = LX_TEXT;
    single_q = 1'b0;
    esc_open = 1'b0;
    rbr_seen = 1'b0;
  endfunction

  // at most two output characters per input character
  function void emit(input logic [CHAR_W-1:0] ch);
    if (n_step < 2) begin
      blanked_text.insert(blanked_text.size(), out_char_t'{ch, 1'b0});
      n_step++;
    end
  endfunction

  function void plain_char(input logic [CHAR_W-1:0] c, input logic last);
    if (c == CH_DQ || c == CH_SQ) begin
      emit(CH_SPACE);
      mode     = LX_STRING;
      single_q = (c == CH_SQ);
      esc_open = 1'b0;
    end else if (c == CH_DASH && !last) begin
      mode = LX_DASH;
    end else begin
      emit(c);
    end
  endfunction

  function void lex_char(input logic [CHAR_W-1:0] raw, input logic last);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] quote;
    out_char_t         tail;
    c      = raw & CHAR_MASK;
    n_step = 0;
    case (mode)
      LX_DASH: begin
        if (c == CH_DASH) begin
          emit(CH_SPACE);
          emit(CH_SPACE);
          mode = LX_DASH2;
        end else begin
          emit(CH_DASH);
          mode = LX_TEXT;
          plain_char(c, last);
        end
      end
      LX_DASH2, LX_DASH_BR: begin
        if (c == CH_NL) begin
          emit(CH_NL);
          mode = LX_TEXT;
        end else if (c == CH_LBR) begin
          emit(CH_SPACE);
          if (mode == LX_DASH2) begin
            mode = LX_DASH_BR;
          end else begin
            mode     = LX_BLOCK;
            rbr_seen = 1'b0;
          end
        end else begin
          emit(CH_SPACE);
          mode = LX_LINE;
        end
      end
      LX_LINE: begin
        if (c == CH_NL) begin
          emit(CH_NL);
          mode = LX_TEXT;
        end else begin
          emit(CH_SPACE);
        end
      end
      LX_BLOCK: begin
        if (c == CH_NL) begin
          emit(CH_NL);
          rbr_seen = 1'b0;
        end else if (c == CH_RBR) begin
          emit(CH_SPACE);
          if (rbr_seen) begin
            rbr_seen = 1'b0;
            mode     = LX_TEXT;
          end else begin
            rbr_seen = 1'b1;
          end
        end else begin
          emit(CH_SPACE);
          rbr_seen = 1'b0;
        end
      end
      LX_STRING: begin
        quote = single_q ? CH_SQ : CH_DQ;
        if (esc_open) begin
          emit((c == CH_NL) ? CH_NL : CH_SPACE);
          esc_open = 1'b0;
        end else if (c == CH_BSL) begin
          emit(CH_SPACE);
          esc_open = 1'b1;
        end else if (c == quote) begin
          emit(CH_SPACE);
          mode = LX_TEXT;
        end else if (c == CH_NL) begin
          emit(CH_NL);
          mode = LX_TEXT;
        end else begin
          emit(CH_SPACE);
        end
      end
      default: begin
        mode = LX_TEXT;
        plain_char(c, last);
      end
    endcase
    if (last) begin
      if (n_step > 0) begin
        tail      = blanked_text.pop_back();
        tail.last = 1'b1;
        blanked_text.insert(blanked_text.size(), tail);
      end
      reset_lexer();
    end
  endfunction

  task automatic report(input string what, input logic [CHAR_W-1:0] got,
                        input logic [CHAR_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %02h, expected %02h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_char_t want;
    if (!rst_n) begin
      reset_lexer();
      blanked_text.delete();
    end else begin
      if (in_tvalid && in_tready) lex_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (blanked_text.size() == 0) begin
          report("unexpected output", out_tdata, 8'h00);
        end else begin
          want = blanked_text.pop_front();
          if (out_tdata !== want.ch) report("out_char", out_tdata, want.ch);
          if (out_tlast !== want.last) report("out_last", 8'(out_tlast), 8'(want.last));
        end
      end
    end
    pending <= blanked_text.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench for the Lua comment and string blanker: clock, reset, stimulus, verdict.
// Depends on lcsb_pkg, lcsb_checker and the block lua_comment_string_blanker.
module testbench
  import lcsb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata   = '0;    // [7:0] in_char
  logic              in_tlast   = 1'b0;  // in_last
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [CHAR_W-1:0] out_tdata;          // [7:0] out_char
  logic              out_tlast;          // out_last

  int   fail_count;
  int   pending;
  int   n_sent     = 0;
  int   cycle_count = 0;
  logic steady     = 1'b0;   // high: neither side idles

  lua_comment_string_blanker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Checker sits beside the block on both streams and owns all comparisons.
  lcsb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure: ready drops at random with a chance of about 15 in a hundred, never while steady is high.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 15);
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One input transaction. Idle gaps are taken before valid rises, so valid
  // is never dropped and raised within one step.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while (!steady && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // Directed text; tlast on the final character only when asked.
  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  // Random-part character: now and then it ends the text, wherever the
  // lexer happens to be.
  task automatic push_src(input logic [CHAR_W-1:0] c);
    send_char(c, $urandom_range(79) == 0);
  endtask

  // Content for strings and comments: mostly letters, with a fair share of
  // the characters the lexer reacts to, plus raw bytes.
  function automatic logic [CHAR_W-1:0] pick_content();
    case ($urandom_range(15))
      0:       return CH_DQ;
      1:       return CH_SQ;
      2:       return CH_BSL;
      3:       return CH_DASH;
      4:       return CH_LBR;
      5:       return CH_RBR;
      6:       return CH_NL;
      7:       return CHAR_W'($urandom_range(255));
      default: return CHAR_W'($urandom_range(97, 122));
    endcase
  endfunction

  // One lexical token of Lua-like text; most are well formed, some broken.
  task automatic feed_token();
    int                kind;
    int                n;
    logic [CHAR_W-1:0] q;
    kind = $urandom_range(12);
    case (kind)
      0, 1, 2: push_src(CHAR_W'($urandom_range(97, 122)));
      3, 4: begin   // string literal, escapes inside, usually closed
        q = $urandom_range(1) ? CH_SQ : CH_DQ;
        push_src(q);
        n = $urandom_range(6);
        repeat (n) begin
          if ($urandom_range(4) == 0) push_src(CH_BSL);
          push_src(pick_content());
        end
        if ($urandom_range(7) != 0) push_src(q);
      end
      5: begin      // line comment
        push_src(CH_DASH);
        push_src(CH_DASH);
        n = $urandom_range(6);
        repeat (n) push_src(pick_content());
        push_src(CH_NL);
      end
      6: begin      // block comment with stray brackets inside
        push_src(CH_DASH);
        push_src(CH_DASH);
        push_src(CH_LBR);
        push_src(CH_LBR);
        n = $urandom_range(8);
        repeat (n) push_src(pick_content());
        push_src(CH_RBR);
        push_src(CH_RBR);
      end
      7: begin      // lone dash followed by anything
        push_src(CH_DASH);
        push_src(pick_content());
      end
      8:  push_src(CH_NL);
      9:  push_src(CHAR_W'($urandom_range(255)));
      10: push_src($urandom_range(1) ? CH_LBR : CH_RBR);
      11: begin     // broken opener: "--[" then whatever
        push_src(CH_DASH);
        push_src(CH_DASH);
        push_src(CH_LBR);
        push_src(pick_content());
      end
      default: push_src(CH_SPACE);
    endcase
  endtask

  initial begin
    int start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    send_text("-x--y\n", 1'b0);      // held dash then other, line comment
    send_text("--\n--[\n", 1'b0);    // newline straight after the openers
    send_text("--[[]\n]]", 1'b0);    // newline breaks a pending close
    send_text("'\\'\"'", 1'b0);      // escaped quote, other quote kind inside
    send_text("\"\\\n\n", 1'b0);     // escaped newline, then newline ends it
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_DASH, 1'b1);        // dash as final character
    send_char(CH_DQ, 1'b0);
    send_char(8'hFF, 1'b1);          // text ends inside a string

    // Random part, with one long stretch where nobody idles.
    start = n_sent;
    while (n_sent - start < RANDOM_ITEMS) begin
      steady = (n_sent - start >= 250) && (n_sent - start < 400);
      feed_token();
    end
    steady = 1'b0;
    send_char(CHAR_W'($urandom_range(97, 122)), 1'b1);
    in_tvalid <= 1'b0;

    // Drain: the checker's pending count is registered, so it lags.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lcsb_pkg.sv
rtl/core/lcsb_scan.sv
rtl/core/lcsb_outq.sv
rtl/core/lua_comment_string_blanker.sv
tb/sv/lcsb_checker.sv
tb/sv/testbench.sv
